>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Boolean check at every clock edge outside reset
`define HVN_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("%m: check failed");

// Same-cycle implication
`define HVN_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication
`define HVN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define HVN_ASSERT_ALWAYS(label, clk, rstn, expr)
`define HVN_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define HVN_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/hvn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hvn_pkg;

    // Grid limits and register layout
    localparam int MAX_GRID_DEF = 1024;
    localparam int GRID_REG_W   = 11;
    localparam int IDX_W        = 10;
    localparam int CFG_IDX_W    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 4'd1;

    localparam logic [GRID_REG_W-1:0] GRID_RESET = 11'd10;

    // Datapath widths
    localparam int HGT_W  = 16;   // Q8.8 height
    localparam int MAG_W  = 16;   // |L-R|, |U-D|
    localparam int SQ_W   = 32;   // squared magnitude
    localparam int SUM_W  = 34;   // s = a^2 + b^2 + c^2
    localparam int SUM5_W = 37;   // 5*s
    localparam int RES_W  = 70;   // residual v^2*2^30 - q^2*s, signed
    localparam int PRD_W  = 52;   // q*s partial products, signed
    localparam int NRM_W  = 15;   // normal magnitude, 0..16384
    localparam int OUT_W  = NRM_W + 1;

    // One digit of the normal magnitude per step
    localparam int NSTEP = 15;

    // v^2 is scaled by 2^30 before the compare against q^2*s
    localparam int Q14_SHIFT = 30;

    localparam logic [SQ_W-1:0]  Y_SQ     = 32'd262144;  // (2.0 in Q8.8)^2
    localparam logic [SUM_W-1:0] TWO_SQ   = 34'd262144;
    localparam logic [NRM_W-1:0] UNIT_Q14 = 15'd16384;
    localparam int               UNIT_INT = 16384;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    // Per-component state of the digit recurrence
    typedef struct packed {
        logic signed [RES_W-1:0] r;   // v^2*2^30 - q^2*s
        logic signed [PRD_W-1:0] p;   // q*s, q = 2n-1
        logic signed [PRD_W-1:0] t;   // p + s*2^k for the current digit
        logic [NRM_W-1:0]        n;   // magnitude found so far
    } hvn_lane_t;

    // One pipeline beat through the recurrence
    typedef struct packed {
        logic             border;
        logic             sign_x;
        logic             sign_z;
        logic [SUM_W-1:0] s;
        logic [SUM5_W-1:0] s5;
        hvn_lane_t [2:0]  lane;
    } hvn_iter_t;

endpackage

`default_nettype wire

>>> rtl/hvn_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One digit of the normalization: decides bit K of each magnitude
module hvn_step
    import hvn_pkg::*;
#(
    parameter int K = 0
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire hvn_iter_t in_iter,
    output logic           out_valid,
    output hvn_iter_t      out_iter
);

    localparam int KM1 = (K > 0) ? K - 1 : 0;

    logic                    valid_reg;
    hvn_iter_t               iter_reg;
    hvn_iter_t               iter_next;
    logic signed [RES_W-1:0] r_try [3];
    logic signed [PRD_W-1:0] s_ext;
    logic signed [PRD_W-1:0] s5_ext;

    // Trial digit: q grows by 2^(K+1), residual drops by T*2^(K+2).
    // Next T is prepared from both outcomes so only one add sits in series.
    always_comb begin
        iter_next = in_iter;
        s_ext     = {{(PRD_W-SUM_W){1'b0}}, in_iter.s};
        s5_ext    = {{(PRD_W-SUM5_W){1'b0}}, in_iter.s5};
        for (int i = 0; i < 3; i++) begin
            r_try[i] = in_iter.lane[i].r - (RES_W'(in_iter.lane[i].t) <<< (K + 2));
            if (!r_try[i][RES_W-1]) begin
                iter_next.lane[i].r    = r_try[i];
                iter_next.lane[i].p    = in_iter.lane[i].p + (s_ext <<< (K + 1));
                iter_next.lane[i].t    = in_iter.lane[i].p + (s5_ext <<< KM1);
                iter_next.lane[i].n[K] = 1'b1;
            end else begin
                iter_next.lane[i].t    = in_iter.lane[i].p + (s_ext <<< KM1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            iter_reg <= iter_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_iter  = iter_reg;

endmodule

`default_nettype wire

>>> rtl/heightmap_vertex_normal_top.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Heightmap vertex normal. Each input beat carries a vertex's row and column
// and the Q8.8 heights of its four neighbors; the block returns the unit
// normal (L-R, 2, U-D)/|.| in Q1.14, each magnitude rounded to nearest with
// ties away from zero, exactly. Vertices on or beyond the grid border return
// (0, 16384, 0). The block takes one beat per cycle while the output is not
// stalled and returns one result per beat, in order, through three
// front stages (differences, squares, sum), one setup stage, fifteen
// shift-and-add stages that each settle one bit of all three
// magnitudes, and the output register. Back pressure stalls only the stages
// that hold data, so empty slots fill while a result waits. grid_rows and
// grid_columns are written through the cfg port (always ready) and must only
// change while no beat is in flight; values above MAX_GRID count as MAX_GRID.
module heightmap_vertex_normal_top
    import hvn_pkg::*;
#(
    parameter int MAX_GRID = MAX_GRID_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [GRID_REG_W-1:0]  cfg_data,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [IDX_W-1:0]       s_vertex_row,
    input  wire logic [IDX_W-1:0]       s_vertex_column,
    input  wire logic [HGT_W-1:0]       s_height_left,
    input  wire logic [HGT_W-1:0]       s_height_right,
    input  wire logic [HGT_W-1:0]       s_height_up,
    input  wire logic [HGT_W-1:0]       s_height_down,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [OUT_W-1:0]     m_normal_x,
    output logic [NRM_W-1:0]            m_normal_y,
    output logic signed [OUT_W-1:0]     m_normal_z
);

    localparam int MG_W = $clog2(MAX_GRID + 1);
    localparam int CW   = (GRID_REG_W > MG_W) ? GRID_REG_W : MG_W;
    localparam logic [CW-1:0] MAX_GRID_C = CW'(MAX_GRID);

    // Configuration registers
    logic [GRID_REG_W-1:0] grid_rows_reg;
    logic [GRID_REG_W-1:0] grid_columns_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg    <= GRID_RESET;
            grid_columns_reg <= GRID_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_GRID_ROWS:    grid_rows_reg    <= cfg_data;
                CFG_GRID_COLUMNS: grid_columns_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage load enables: a stage loads when empty or when the next one loads
    logic              a_ld, b_ld, c_ld, out_ld;
    logic [NSTEP:0]    step_ld;
    logic [NSTEP:0]    step_valid;
    hvn_iter_t         step_iter [NSTEP+1];

    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, m_valid_reg;

    assign out_ld         = !m_valid_reg || m_ready;
    assign step_ld[NSTEP] = !step_valid[NSTEP] || out_ld;

    genvar g;
    generate
        for (g = 0; g < NSTEP; g++) begin : g_ld
            assign step_ld[g] = !step_valid[g] || step_ld[g+1];
        end
    endgenerate

    assign c_ld    = !c_valid_reg || step_ld[0];
    assign b_ld    = !b_valid_reg || c_ld;
    assign a_ld    = !a_valid_reg || b_ld;
    assign s_ready = a_ld;

    // Stage A: border test, neighbor differences and their magnitudes
    logic [CW-1:0]         rows_eff;
    logic [CW-1:0]         cols_eff;
    logic                  interior;
    logic signed [HGT_W:0] diff_x;
    logic signed [HGT_W:0] diff_z;

    always_comb begin
        rows_eff = (CW'(grid_rows_reg) > MAX_GRID_C) ? MAX_GRID_C : CW'(grid_rows_reg);
        cols_eff = (CW'(grid_columns_reg) > MAX_GRID_C) ? MAX_GRID_C : CW'(grid_columns_reg);
        interior = (s_vertex_row != '0) && (s_vertex_column != '0) &&
                   ((CW'(s_vertex_row) + CW'(1)) < rows_eff) &&
                   ((CW'(s_vertex_column) + CW'(1)) < cols_eff);
        diff_x   = $signed({1'b0, s_height_left}) - $signed({1'b0, s_height_right});
        diff_z   = $signed({1'b0, s_height_up}) - $signed({1'b0, s_height_down});
    end

    logic             a_border_reg, a_sign_x_reg, a_sign_z_reg;
    logic [MAG_W-1:0] a_mag_x_reg, a_mag_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ld) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ld) begin
            a_border_reg <= !interior;
            a_sign_x_reg <= diff_x[HGT_W];
            a_sign_z_reg <= diff_z[HGT_W];
            a_mag_x_reg  <= diff_x[HGT_W] ? MAG_W'(-diff_x) : MAG_W'(diff_x);
            a_mag_z_reg  <= diff_z[HGT_W] ? MAG_W'(-diff_z) : MAG_W'(diff_z);
        end
    end

    // Stage B: squares
    logic            b_border_reg, b_sign_x_reg, b_sign_z_reg;
    logic [SQ_W-1:0] b_sq_x_reg, b_sq_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ld) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ld) begin
            b_border_reg <= a_border_reg;
            b_sign_x_reg <= a_sign_x_reg;
            b_sign_z_reg <= a_sign_z_reg;
            b_sq_x_reg   <= SQ_W'(a_mag_x_reg) * SQ_W'(a_mag_x_reg);
            b_sq_z_reg   <= SQ_W'(a_mag_z_reg) * SQ_W'(a_mag_z_reg);
        end
    end

    // Stage C: squared length s
    logic             c_border_reg, c_sign_x_reg, c_sign_z_reg;
    logic [SQ_W-1:0]  c_sq_x_reg, c_sq_z_reg;
    logic [SUM_W-1:0] c_s_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ld) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ld) begin
            c_border_reg <= b_border_reg;
            c_sign_x_reg <= b_sign_x_reg;
            c_sign_z_reg <= b_sign_z_reg;
            c_sq_x_reg   <= b_sq_x_reg;
            c_sq_z_reg   <= b_sq_z_reg;
            c_s_reg      <= SUM_W'(b_sq_x_reg) + SUM_W'(b_sq_z_reg) + TWO_SQ;
        end
    end

    // Stage D: recurrence setup with n = 0, q = -1
    hvn_iter_t               d_iter_reg;
    hvn_iter_t               d_iter_next;
    logic signed [PRD_W-1:0] c_s_ext;
    logic [SQ_W-1:0]         lane_sq [3];

    always_comb begin
        c_s_ext    = {{(PRD_W-SUM_W){1'b0}}, c_s_reg};
        lane_sq[LANE_X] = c_sq_x_reg;
        lane_sq[LANE_Y] = Y_SQ;
        lane_sq[LANE_Z] = c_sq_z_reg;
        d_iter_next.border = c_border_reg;
        d_iter_next.sign_x = c_sign_x_reg;
        d_iter_next.sign_z = c_sign_z_reg;
        d_iter_next.s      = c_s_reg;
        d_iter_next.s5     = SUM5_W'(c_s_reg) + (SUM5_W'(c_s_reg) << 2);
        for (int i = 0; i < 3; i++) begin
            d_iter_next.lane[i].r = (RES_W'(lane_sq[i]) << Q14_SHIFT) - RES_W'(c_s_reg);
            d_iter_next.lane[i].p = -c_s_ext;
            d_iter_next.lane[i].t = (c_s_ext <<< (NSTEP - 1)) - c_s_ext;
            d_iter_next.lane[i].n = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (step_ld[0]) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_ld[0]) begin
            d_iter_reg <= d_iter_next;
        end
    end

    assign step_valid[0] = d_valid_reg;
    assign step_iter[0]  = d_iter_reg;

    // Digit stages, most significant bit first
    generate
        for (g = 0; g < NSTEP; g++) begin : g_step
            hvn_step #(
                .K (NSTEP - 1 - g)
            ) u_step (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (step_ld[g+1]),
                .in_valid  (step_valid[g]),
                .in_iter   (step_iter[g]),
                .out_valid (step_valid[g+1]),
                .out_iter  (step_iter[g+1])
            );
        end
    endgenerate

    // Output stage: signs and border override
    hvn_iter_t                last_iter;
    logic [OUT_W-1:0]         mag_x, mag_z;
    logic signed [OUT_W-1:0]  m_normal_x_reg, m_normal_x_next;
    logic [NRM_W-1:0]         m_normal_y_reg, m_normal_y_next;
    logic signed [OUT_W-1:0]  m_normal_z_reg, m_normal_z_next;

    always_comb begin
        last_iter = step_iter[NSTEP];
        mag_x     = {1'b0, last_iter.lane[LANE_X].n};
        mag_z     = {1'b0, last_iter.lane[LANE_Z].n};
        if (last_iter.border) begin
            m_normal_x_next = '0;
            m_normal_y_next = UNIT_Q14;
            m_normal_z_next = '0;
        end else begin
            m_normal_x_next = last_iter.sign_x ? (~mag_x + OUT_W'(1)) : mag_x;
            m_normal_y_next = last_iter.lane[LANE_Y].n;
            m_normal_z_next = last_iter.sign_z ? (~mag_z + OUT_W'(1)) : mag_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ld) begin
            m_valid_reg <= step_valid[NSTEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ld) begin
            m_normal_x_reg <= m_normal_x_next;
            m_normal_y_reg <= m_normal_y_next;
            m_normal_z_reg <= m_normal_z_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_normal_x = m_normal_x_reg;
    assign m_normal_y = m_normal_y_reg;
    assign m_normal_z = m_normal_z_reg;

    // Checks
    `HVN_ASSERT_ALWAYS(a_open_when_drained, aclk, aresetn, m_valid_reg || s_ready)
    `HVN_ASSERT_IMPLY(a_y_range, aclk, aresetn, m_valid_reg, m_normal_y_reg <= UNIT_Q14)
    `HVN_ASSERT_IMPLY(a_xz_range, aclk, aresetn, m_valid_reg, (int'(m_normal_x_reg) >= -UNIT_INT) && (int'(m_normal_x_reg) <= UNIT_INT) && (int'(m_normal_z_reg) >= -UNIT_INT) && (int'(m_normal_z_reg) <= UNIT_INT))
    `HVN_ASSERT_IMPLY(a_residual_sign, aclk, aresetn, step_valid[NSTEP], ((last_iter.lane[LANE_X].n == '0) || !last_iter.lane[LANE_X].r[RES_W-1]) && ((last_iter.lane[LANE_Y].n == '0) || !last_iter.lane[LANE_Y].r[RES_W-1]) && ((last_iter.lane[LANE_Z].n == '0) || !last_iter.lane[LANE_Z].r[RES_W-1]))
    `HVN_ASSERT_NEXT(a_border_up, aclk, aresetn, step_valid[NSTEP] && last_iter.border && out_ld, m_valid_reg && (m_normal_y_reg == UNIT_Q14) && (m_normal_x_reg == '0) && (m_normal_z_reg == '0))

endmodule

`default_nettype wire
